// ----- rtl/core/rlpg_pkg.sv -----
// Shared types, constants and helper functions of the rainbow pattern generator.
package rlpg_pkg;

    // Register indexes on the configuration port
    localparam logic RegMode       = 1'b0;
    localparam logic RegLightCount = 1'b1;

    // Reset values of the configuration registers
    localparam logic [3:0] ModeReset       = 4'd0;
    localparam logic [8:0] LightCountReset = 9'd50;

    // Mode decoding
    localparam logic [3:0] ModeCount = 4'd12;
    localparam logic [1:0] KindRedGreen  = 2'd0;
    localparam logic [1:0] KindGreenBlue = 2'd1;
    localparam logic [1:0] KindBlueRed   = 2'd2;
    localparam logic [1:0] KindWheel     = 2'd3;
    localparam logic [1:0] FormPlain     = 2'd0;
    localparam logic [1:0] FormSpread    = 2'd1;
    localparam logic [1:0] FormInterlace = 2'd2;

    // Light count saturation
    localparam logic [8:0] MaxLights = 9'd256;

    // Half periods for the interlaced form
    localparam logic [8:0] LineHalf  = 9'd128;
    localparam logic [8:0] WheelHalf = 9'd192;

    // Wheel segment codes
    localparam logic [1:0] SegFirst  = 2'd0;
    localparam logic [1:0] SegSecond = 2'd1;

    // Frame step counter wraps at 768
    localparam logic [9:0] StepLast = 10'd767;

    // Divider: dividend is led_index times 384 at most, 17 bits
    localparam int          DivBits  = 17;
    localparam logic [4:0]  DivCount = 5'(DivBits - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture an input word
        logic div_step;  // one restoring-division step
        logic finish;    // load the result registers, advance the step
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic spread_div; // the word at the input needs a division
        logic div_last;   // the division step under way is the last one
    } t_status;

    // Residue modulo three of an 11-bit value; base-4 digits are each 1 mod 3
    function automatic logic [1:0] mod3(input logic [10:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [1:0] r;
        s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) + 5'(v[9:8])
            + 5'(v[10]);
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            r = 2'(t - 3'd6);
        end else if (t >= 3'd3) begin
            r = 2'(t - 3'd3);
        end else begin
            r = t[1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/rlpg_ctrl.sv -----
// Controller state machine: sequences load, division and result hand-off.
module rlpg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  rlpg_pkg::t_status i_status,
    output rlpg_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    // Output register can take a word when empty or being drained
    assign out_free = !r_out_valid || !i_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.spread_div ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result until taken, refill on finish
    assign n_out_valid = (r_out_valid && i_stall) || o_cmd.finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_spread_goes_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_status.spread_div) |=> (r_state == S_DIV))
        else $error("spread word did not enter division");

    a_div_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_last) |=> (r_state == S_DIV))
        else $error("division left early");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("finished word not presented");

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input not stalled while busy");

endmodule

// ----- rtl/core/rlpg_dp.sv -----
// Datapath: word capture, serial divider, position and color lookup, step counter.
module rlpg_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rlpg_pkg::t_cmd    i_cmd,
    output rlpg_pkg::t_status o_status,
    input  logic [3:0]        i_mode,
    input  logic [8:0]        i_light_count,
    input  logic [7:0]        i_led_index,
    input  logic              i_frame_end,
    output logic [6:0]        o_red,
    output logic [6:0]        o_green,
    output logic [6:0]        o_blue
);

    logic [3:0]  mode_m;
    logic [1:0]  in_kind;
    logic [1:0]  in_form;
    logic [8:0]  lc_sat;
    logic [16:0] dividend;

    logic [7:0]  r_idx;
    logic        r_last;
    logic [1:0]  r_kind;
    logic [1:0]  r_form;
    logic [8:0]  r_lc;
    logic [16:0] r_quo;
    logic [7:0]  r_rem;
    logic [4:0]  r_cnt;
    logic [9:0]  r_step;
    logic [6:0]  r_red;
    logic [6:0]  r_green;
    logic [6:0]  r_blue;

    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        ge;

    logic [8:0]  half;
    logic [16:0] base;
    logic [17:0] sum;
    logic [1:0]  seg;
    logic [6:0]  up;
    logic [6:0]  down;
    logic [6:0]  n_red;
    logic [6:0]  n_green;
    logic [6:0]  n_blue;

    // Decode mode modulo twelve and saturate the light count
    assign mode_m  = (i_mode >= rlpg_pkg::ModeCount) ? (i_mode - rlpg_pkg::ModeCount) : i_mode;
    assign in_kind = mode_m[1:0];
    assign in_form = mode_m[3:2];
    assign lc_sat  = (i_light_count > rlpg_pkg::MaxLights) ? rlpg_pkg::MaxLights
                                                           : i_light_count;

    // Index times period: 256 is a shift, 384 adds a second shift
    assign dividend = (in_kind == rlpg_pkg::KindWheel)
                    ? ({1'b0, i_led_index, 8'b0} + {2'b0, i_led_index, 7'b0})
                    : {1'b0, i_led_index, 8'b0};

    assign o_status.spread_div = (in_form == rlpg_pkg::FormSpread) && (lc_sat != 9'd0);
    assign o_status.div_last   = (r_cnt == 5'd0);

    // One restoring-division step: quotient bits shift in behind the dividend
    assign trial = {r_rem, r_quo[16]};
    assign ge    = (trial >= r_lc);
    assign diff  = trial - r_lc;

    // Capture the word, then iterate the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx  <= i_led_index;
            r_last <= i_frame_end;
            r_kind <= in_kind;
            r_form <= in_form;
            r_lc   <= lc_sat;
            r_quo  <= dividend;
            r_rem  <= 8'd0;
            r_cnt  <= rlpg_pkg::DivCount;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[15:0], ge};
            r_rem <= ge ? diff[7:0] : trial[7:0];
            r_cnt <= r_cnt - 5'd1;
        end
    end

    // Base position by form
    assign half = (r_kind == rlpg_pkg::KindWheel) ? rlpg_pkg::WheelHalf : rlpg_pkg::LineHalf;

    always_comb begin
        case (r_form)
            rlpg_pkg::FormSpread: begin
                base = (r_lc == 9'd0) ? 17'd0 : r_quo;
            end
            rlpg_pkg::FormInterlace: begin
                base = 17'(r_idx) + (r_idx[0] ? 17'd0 : 17'(half));
            end
            default: begin
                base = 17'(r_idx);
            end
        endcase
    end

    // Position: 128-wide segments; ramps wrap at 256, the wheel at three segments
    assign sum  = 18'(base) + 18'(r_step);
    assign up   = sum[6:0];
    assign down = ~up;
    assign seg  = (r_kind == rlpg_pkg::KindWheel) ? rlpg_pkg::mod3(sum[17:7])
                                                  : {1'b0, sum[7]};

    // Color lookup
    always_comb begin
        n_red   = 7'd0;
        n_green = 7'd0;
        n_blue  = 7'd0;
        case (r_kind)
            rlpg_pkg::KindRedGreen: begin
                if (seg == rlpg_pkg::SegFirst) begin
                    n_red = down; n_green = up;
                end else begin
                    n_red = up; n_green = down;
                end
            end
            rlpg_pkg::KindGreenBlue: begin
                if (seg == rlpg_pkg::SegFirst) begin
                    n_green = down; n_blue = up;
                end else begin
                    n_green = up; n_blue = down;
                end
            end
            rlpg_pkg::KindBlueRed: begin
                if (seg == rlpg_pkg::SegFirst) begin
                    n_red = up; n_blue = down;
                end else begin
                    n_red = down; n_blue = up;
                end
            end
            default: begin
                if (seg == rlpg_pkg::SegFirst) begin
                    n_red = down; n_green = up;
                end else if (seg == rlpg_pkg::SegSecond) begin
                    n_green = down; n_blue = up;
                end else begin
                    n_blue = down; n_red = up;
                end
            end
        endcase
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    // Advance the frame step after the last word of a frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 10'd0;
        end else if (i_cmd.finish && r_last) begin
            r_step <= (r_step == rlpg_pkg::StepLast) ? 10'd0 : (r_step + 10'd1);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ----- rtl/core/rainbow_led_pattern_generator.sv -----
// Top level of the rainbow pattern generator: register port, controller, datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_stall  | i_led_index[7:0], i_frame_end
//  output  | out       | o_valid / i_stall  | o_red[6:0], o_green[6:0], o_blue[6:0]
//  config  | in        | psel/penable/pready| paddr[2:0], pwdata, prdata (32 bits)
//
//  One word at a time: each word is loaded and then finished; spread modes with
//  a nonzero light count run the divider in between (load, 17 divider steps,
//  finish); spread modes with a zero light count skip the divider.
//  The divider is a 17-step restoring divider for index*period/light_count.
//  The result register frees the input side: a new word is taken while the
//  previous result still waits; finishing waits only if that result is not taken.
//  Synchronous active-low reset clears the state machine, result valid, the
//  frame step and the registers (mode 0, light count 50).
module rainbow_led_pattern_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_led_index,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_red,
    output logic [6:0]  o_green,
    output logic [6:0]  o_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]        r_mode;
    logic [8:0]        r_light_count;
    logic              cfg_write;
    rlpg_pkg::t_cmd    cmd;
    rlpg_pkg::t_status status;

    // Register port: no wait states, pready is always high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= rlpg_pkg::ModeReset;
            r_light_count <= rlpg_pkg::LightCountReset;
        end else if (cfg_write) begin
            case (paddr[2])
                rlpg_pkg::RegMode:       r_mode        <= pwdata[3:0];
                rlpg_pkg::RegLightCount: r_light_count <= pwdata[8:0];
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            rlpg_pkg::RegMode:       prdata = {28'd0, r_mode};
            rlpg_pkg::RegLightCount: prdata = {23'd0, r_light_count};
            default:                 prdata = 32'd0;
        endcase
    end

    rlpg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rlpg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_mode        (r_mode),
        .i_light_count (r_light_count),
        .i_led_index   (i_led_index),
        .i_frame_end   (i_frame_end),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue)
    );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the rainbow pattern generator with a color predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WordTarget  = 700;
    localparam int PhaseWords  = 45;
    localparam int IdleLimit   = 2000;
    localparam int SettleTicks = 30;
    localparam logic [2:0] AddrMode       = {rlpg_pkg::RegMode, 2'b00};
    localparam logic [2:0] AddrLightCount = {rlpg_pkg::RegLightCount, 2'b00};
    localparam logic [8:0] LcCorners [8] =
        '{9'd0, 9'd1, 9'd2, 9'd50, 9'd255, 9'd256, 9'd257, 9'd511};

    // Expected colors per accepted word, with a private copy of registers and step
    class rgb_scoreboard;
        typedef struct {
            logic [6:0] red;
            logic [6:0] green;
            logic [6:0] blue;
        } t_rgb;

        logic [3:0] mode;
        logic [8:0] light_count;
        logic [9:0] frame_step;
        int         errors;
        t_rgb       colours_due[$];

        function new();
            mode         = rlpg_pkg::ModeReset;
            light_count  = rlpg_pkg::LightCountReset;
            frame_step   = '0;
            errors       = 0;
        endfunction

        function t_rgb rainbow_colour(int unsigned idx);
            int unsigned m, kind, form, period, lc, base, pos, up, down;
            t_rgb c;
            m      = mode % rlpg_pkg::ModeCount;
            kind   = m % 4;
            form   = m / 4;
            period = (kind == rlpg_pkg::KindWheel) ? 384 : 256;
            lc     = (light_count > rlpg_pkg::MaxLights) ? rlpg_pkg::MaxLights : light_count;
            if (form == rlpg_pkg::FormSpread) begin
                base = (lc == 0) ? 0 : (idx * period) / lc;
            end else if (form == rlpg_pkg::FormInterlace) begin
                base = idx + ((idx % 2 == 0) ? period / 2 : 0);
            end else begin
                base = idx;
            end
            pos  = (base + frame_step) % period;
            up   = pos % 128;
            down = 127 - up;
            c.red   = '0;
            c.green = '0;
            c.blue  = '0;
            // Wheel walks red, green, blue; each ramp goes out and back
            if (kind == rlpg_pkg::KindWheel) begin
                if (pos / 128 == rlpg_pkg::SegFirst) begin
                    c.red = 7'(down); c.green = 7'(up);
                end else if (pos / 128 == rlpg_pkg::SegSecond) begin
                    c.green = 7'(down); c.blue = 7'(up);
                end else begin
                    c.blue = 7'(down); c.red = 7'(up);
                end
            end else if (kind == rlpg_pkg::KindRedGreen) begin
                if (pos < 128) begin
                    c.red = 7'(down); c.green = 7'(up);
                end else begin
                    c.red = 7'(up); c.green = 7'(down);
                end
            end else if (kind == rlpg_pkg::KindGreenBlue) begin
                if (pos < 128) begin
                    c.green = 7'(down); c.blue = 7'(up);
                end else begin
                    c.green = 7'(up); c.blue = 7'(down);
                end
            end else begin
                if (pos < 128) begin
                    c.red = 7'(up); c.blue = 7'(down);
                end else begin
                    c.red = 7'(down); c.blue = 7'(up);
                end
            end
            return c;
        endfunction

        function void note_word(logic [7:0] idx, logic last);
            colours_due.push_back(rainbow_colour(idx));
            // Advance the step after the last light of a frame
            if (last) begin
                if (frame_step == rlpg_pkg::StepLast) begin
                    frame_step = '0;
                end else begin
                    frame_step = frame_step + 10'd1;
                end
            end
        endfunction

        function void check_result(logic [6:0] red, logic [6:0] green, logic [6:0] blue);
            t_rgb want;
            if (colours_due.size() == 0) begin
                $error("result with no word pending: red %0d green %0d blue %0d",
                       red, green, blue);
                errors++;
                return;
            end
            want = colours_due.pop_front();
            if (red !== want.red) begin
                $error("red: expected %0d, got %0d", want.red, red);
                errors++;
            end
            if (green !== want.green) begin
                $error("green: expected %0d, got %0d", want.green, green);
                errors++;
            end
            if (blue !== want.blue) begin
                $error("blue: expected %0d, got %0d", want.blue, blue);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_led_index;
    logic        i_frame_end;
    logic        o_valid;
    logic        i_stall;
    logic [6:0]  o_red;
    logic [6:0]  o_green;
    logic [6:0]  o_blue;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgb_scoreboard sb = new();
    bit calm;
    int idle_cycles = 0;
    int words_sent;

    rainbow_led_pattern_generator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_led_index (i_led_index),
        .i_frame_end (i_frame_end),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Record accepted words, check accepted results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_red, o_green, o_blue);
            end
            if (i_valid && !o_stall) begin
                sb.note_word(i_led_index, i_frame_end);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall) || (psel && penable)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stall the result side for a random count, then take one word
    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = calm ? 0 : $urandom_range(0, 13);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == AddrMode) begin
            sb.mode = data[3:0];
        end else begin
            sb.light_count = data[8:0];
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.colours_due.size() != 0);
        repeat (SettleTicks) @(posedge i_clk);
    endtask

    task automatic set_pattern(input logic [3:0] mode, input logic [8:0] lc);
        drain();
        reg_write(AddrMode, 32'(mode));
        reg_write(AddrLightCount, 32'(lc));
    endtask

    // Offer one word, hold it until taken, then idle for a random gap
    task automatic send_word(input logic [7:0] idx, input logic last);
        int gap;
        i_valid     <= 1'b1;
        i_led_index <= idx;
        i_frame_end <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic probe(input logic [3:0] mode, input logic [8:0] lc,
                         input logic [7:0] idx, input logic last);
        if (mode != sb.mode || lc != sb.light_count) begin
            set_pattern(mode, lc);
        end
        send_word(idx, last);
    endtask

    initial begin
        logic [3:0] mode;
        logic [8:0] lc;
        int unsigned lc_eff;
        logic [7:0] idx;
        int phase;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_led_index <= '0;
        i_frame_end <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        calm        = 1'b0;
        words_sent  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every mode, divisor corners, wrapped modes
        probe(4'd0,  9'd50,  8'd0,   1'b0);
        probe(4'd0,  9'd50,  8'd255, 1'b1);
        probe(4'd1,  9'd50,  8'd127, 1'b0);
        probe(4'd2,  9'd50,  8'd128, 1'b1);
        probe(4'd3,  9'd50,  8'd200, 1'b1);
        probe(4'd3,  9'd50,  8'd255, 1'b0);
        probe(4'd4,  9'd1,   8'd255, 1'b1);   // index far past the light count
        probe(4'd5,  9'd0,   8'd200, 1'b0);   // zero lights: no division
        probe(4'd6,  9'd256, 8'd255, 1'b1);
        probe(4'd7,  9'd511, 8'd255, 1'b0);   // light count saturates
        probe(4'd7,  9'd257, 8'd128, 1'b1);
        probe(4'd8,  9'd50,  8'd0,   1'b0);   // even index gets half a period
        probe(4'd8,  9'd50,  8'd1,   1'b1);
        probe(4'd9,  9'd50,  8'd254, 1'b0);
        probe(4'd10, 9'd50,  8'd255, 1'b1);
        probe(4'd11, 9'd50,  8'd2,   1'b0);
        probe(4'd11, 9'd50,  8'd255, 1'b1);
        probe(4'd12, 9'd50,  8'd64,  1'b0);   // modes above eleven fold back
        probe(4'd13, 9'd50,  8'd191, 1'b1);
        probe(4'd14, 9'd50,  8'd33,  1'b0);
        probe(4'd15, 9'd50,  8'd250, 1'b1);

        // Random phases until the word budget is spent
        phase = 0;
        while (words_sent < WordTarget) begin
            mode = (phase < 16) ? 4'(phase) : 4'($urandom_range(0, 15));
            lc   = (phase % 2 == 0) ? LcCorners[(phase / 2) % 8]
                                    : 9'($urandom_range(0, 511));
            set_pattern(mode, lc);
            calm   = ($urandom_range(0, 3) == 0);
            lc_eff = (lc > rlpg_pkg::MaxLights) ? rlpg_pkg::MaxLights : lc;
            for (int k = 0; k < PhaseWords; k++) begin
                if (lc_eff > 0 && $urandom_range(0, 3) != 0) begin
                    idx = 8'($urandom_range(0, lc_eff - 1));
                end else begin
                    idx = 8'($urandom_range(0, 255));
                end
                send_word(idx, $urandom_range(0, 15) != 0);
            end
            phase++;
        end

        // Let the last results come home, then report
        calm = 1'b0;
        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
